// File: rtl/core/dag_pkg.sv
// ----------------------------------------------------------------------------
// dag_pkg
// Shared types, codes and constant tables for the distance attenuation gain
// pipeline.
// ----------------------------------------------------------------------------
package dag_pkg;

  // log2 results: Q30 with an integer part up to 31
  localparam int LOG_W     = 35;
  // normalize (2 stages) plus one squaring round per fraction bit
  localparam int LOG_LAT   = 32;
  // quotient bits of the restoring divider
  localparam int DIV_QB    = 28;
  // conditional multiply rounds of the exp2 unit
  localparam int EXP_ROUNDS = 30;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_EXP    = 2'd1,
    MODE_LOG    = 2'd2,
    MODE_SMOOTH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLS_CURVE = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_ZERO  = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_INNER   = 2'd1,
    REG_OUTER   = 2'd2,
    REG_FALLOFF = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic  valid;
    cls_t  cls;
    mode_t mode;
  } ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-idx) in Q30, built by repeated square roots of one half
  function automatic logic [29:0] exp_factor(input int idx);
    logic [63:0] s;
    s = isqrt64(64'd1 << 59);
    for (int i = 1; i < EXP_ROUNDS; i++) begin
      if (i < idx) begin
        s = isqrt64(s << 30);
      end
    end
    return s[29:0];
  endfunction

endpackage

// File: rtl/core/dag_log2.sv
// ----------------------------------------------------------------------------
// dag_log2
// Pipelined log2 of a 32-bit integer, Q30 result: normalize, then one
// truncating squaring round per fraction bit.
// ----------------------------------------------------------------------------
module dag_log2
  import dag_pkg::*;
(
  input  logic             clk,
  input  logic [31:0]      x,
  output logic [LOG_W-1:0] y
);

  logic [31:0]      x0;
  logic [4:0]       e0;
  logic [4:0]       e_c;
  logic [31:0]      m [0:30];
  logic [LOG_W-1:0] r [0:30];

  // leading one position; zero maps to zero
  always_comb begin
    e_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        e_c = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    x0   <= x;
    e0   <= e_c;
    m[0] <= x0 << (5'd31 - e0);
    r[0] <= LOG_W'({e0, 30'b0});
  end

  for (genvar i = 1; i <= 30; i++) begin : g_round
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m[i-1]) * 64'(m[i-1]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (t[32]) begin
        m[i] <= t[32:1];
        r[i] <= r[i-1] | (LOG_W'(1) << (30 - i));
      end else begin
        m[i] <= t[31:0];
        r[i] <= r[i-1];
      end
    end
  end

  assign y = r[30];

endmodule

// File: rtl/core/distance_attenuation_gain.sv
// ----------------------------------------------------------------------------
// distance_attenuation_gain
// Maps a listener-to-source distance (unsigned Q16.16) to a playback gain
// (unsigned Q1.15) along a configurable attenuation curve.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive distance and raise start; the request is taken at
//   any rising edge with start high and busy low. busy never rises, so one
//   request can enter every cycle.
//   Result channel: done pulses for one cycle with gain valid in that cycle.
//   The receiver cannot stall; results leave in request order, one per
//   request, and each result is taken at the edge that ends the cycle in
//   which done is high.
//   Throughput is one request per cycle. Requests pass through the log2
//   units (32 stages, one squaring per fraction bit), the restoring divider
//   (28 stages, one quotient bit each) and four stages of polynomial or
//   rounding; the exp2 branch runs beside the divider in 32 stages.
//   Configuration: APB writes at byte address 4*i (mode, inner radius,
//   outer radius, falloff exponent). Write only while no request is in
//   flight. pready is always high.
//   Reset: clears the pipeline valid bits and loads the register defaults
//   (linear mode, inner 0, outer 100.0, falloff 1.0). No clearing pass.
// ----------------------------------------------------------------------------
module distance_attenuation_gain
  import dag_pkg::*;
#(
  parameter int DIST_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] distance,
  output logic        done,
  output logic [15:0] gain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int GF  = GAIN_FRAC_BITS;
  localparam int GW  = GF + 1;
  localparam int DW  = LOG_W;
  localparam int NW  = (GF + 36 > 60) ? GF + 36 : 60;
  localparam int S_LOG = LOG_LAT + 1;              // log results registered
  localparam int LAT = LOG_LAT + DIV_QB + 7;        // accept edge to done
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GF{1'b0}}};
  localparam longint OUTER_RAW = longint'(100) << DIST_FRAC_BITS;
  localparam logic [31:0] OUTER_RST =
    (OUTER_RAW > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(OUTER_RAW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  mode_t       attenuation_mode;
  logic [31:0] near_radius;
  logic [31:0] far_radius;
  logic [15:0] falloff_exponent;
  reg_idx_t    reg_sel;

  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attenuation_mode <= MODE_LINEAR;
      near_radius      <= '0;
      far_radius       <= OUTER_RST;
      falloff_exponent <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_MODE:    attenuation_mode <= mode_t'(pwdata[1:0]);
        REG_INNER:   near_radius      <= pwdata;
        REG_OUTER:   far_radius       <= pwdata;
        REG_FALLOFF: falloff_exponent <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:    prdata = 32'(attenuation_mode);
      REG_INNER:   prdata = near_radius;
      REG_OUTER:   prdata = far_radius;
      REG_FALLOFF: prdata = 32'(falloff_exponent);
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture the request
  // --------------------------------------------------------------------------
  logic        vld0;
  logic [31:0] dist0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy;
    end
    dist0 <= distance;
  end

  // --------------------------------------------------------------------------
  // Stage 1: classify against the radii, pick the log2 operands
  // --------------------------------------------------------------------------
  ctl_t        ctl [1:LAT];
  ctl_t        ctl1_c;
  logic [31:0] rnum_c;
  logic [31:0] span_c;
  logic [31:0] lx1, lx2, lx3;
  logic [31:0] sb_rnum [1:S_LOG];
  logic [31:0] sb_span [1:S_LOG];

  assign rnum_c = far_radius - dist0;
  assign span_c = far_radius - near_radius;

  always_comb begin
    ctl1_c.valid = vld0;
    ctl1_c.mode  = attenuation_mode;
    if (dist0 <= near_radius) begin
      ctl1_c.cls = CLS_ONE;
    end else if (dist0 >= far_radius) begin
      ctl1_c.cls = CLS_ZERO;
    end else if (attenuation_mode == MODE_LOG && near_radius == '0) begin
      ctl1_c.cls = CLS_ZERO;
    end else begin
      ctl1_c.cls = CLS_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[1] <= '0;
    end else begin
      ctl[1] <= ctl1_c;
    end
    sb_rnum[1] <= rnum_c;
    sb_span[1] <= span_c;
    // exponential: log of r and span; logarithmic: log of d, outer, inner
    lx1 <= (attenuation_mode == MODE_EXP) ? rnum_c : dist0;
    lx2 <= (attenuation_mode == MODE_EXP) ? span_c : far_radius;
    lx3 <= near_radius;
  end

  // advance control and side band alongside the data
  for (genvar k = 2; k <= LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  for (genvar k = 2; k <= S_LOG; k++) begin : g_sb
    always_ff @(posedge clk) begin
      sb_rnum[k] <= sb_rnum[k-1];
      sb_span[k] <= sb_span[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..33: three log2 units
  // --------------------------------------------------------------------------
  logic [LOG_W-1:0] l1, l2, l3;

  dag_log2 u_log_a (.clk(clk), .x(lx1), .y(l1));
  dag_log2 u_log_b (.clk(clk), .x(lx2), .y(l2));
  dag_log2 u_log_c (.clk(clk), .x(lx3), .y(l3));

  // --------------------------------------------------------------------------
  // Stage 34: set up the divider and the exp2 exponent
  // --------------------------------------------------------------------------
  logic [DW-1:0]     div_r [0:DIV_QB];
  logic [DW-1:0]     div_d [0:DIV_QB];
  logic [DIV_QB-1:0] div_q [0:DIV_QB];
  logic [LOG_W-1:0]  exp_a;
  logic [NW-1:0]     div_n_c;
  logic [DW-1:0]     div_d_c;
  logic [LOG_W-1:0]  lnum_c;
  logic [LOG_W-1:0]  lden_c;
  logic [31:0]       rn33, sp33;

  assign rn33   = sb_rnum[S_LOG];
  assign sp33   = sb_span[S_LOG];
  assign lnum_c = (l2 > l1) ? l2 - l1 : '0;
  assign lden_c = l2 - l3;

  always_comb begin
    case (ctl[S_LOG].mode)
      MODE_SMOOTH: begin
        div_n_c = NW'(rn33) << 28;
        div_d_c = DW'(sp33);
      end
      MODE_LOG: begin
        if (l2 > l3) begin
          div_n_c = (NW'(lnum_c) << GF) + NW'(lden_c >> 1);
          div_d_c = lden_c;
        end else begin
          // radii with equal log2: fall back to the linear curve
          div_n_c = (NW'(rn33) << GF) + NW'(sp33 >> 1);
          div_d_c = DW'(sp33);
        end
      end
      default: begin
        div_n_c = (NW'(rn33) << GF) + NW'(sp33 >> 1);
        div_d_c = DW'(sp33);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    div_r[0] <= DW'(div_n_c >> DIV_QB);
    div_q[0] <= div_n_c[DIV_QB-1:0];
    div_d[0] <= div_d_c;
    // exponential: l1 = log2(r), l2 = log2(span)
    exp_a    <= lnum_c;
  end

  // --------------------------------------------------------------------------
  // Stages 35..62: restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_QB; k++) begin : g_div
    logic [DW:0] rt;
    logic        ge;
    assign rt = {div_r[k], div_q[k][DIV_QB-1]};
    assign ge = rt >= {1'b0, div_d[k]};
    always_ff @(posedge clk) begin
      div_r[k+1] <= ge ? DW'(rt - {1'b0, div_d[k]}) : rt[DW-1:0];
      div_q[k+1] <= {div_q[k][DIV_QB-2:0], ge};
      div_d[k+1] <= div_d[k];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 63..66: smootherstep polynomial on r = quotient (Q28)
  // --------------------------------------------------------------------------
  logic [DIV_QB-1:0] sm_r1, sm_r2, sm_r3;
  logic [31:0]       sm_p;
  logic [32:0]       sm_s;
  logic [31:0]       sm_g;
  logic [31:0]       q_d [0:3];
  logic [32:0]       sm_p_c;

  assign sm_p_c = (33'(sm_r2) << 2) + (33'(sm_r2) << 1) + (33'd10 << 28)
                - ((33'(sm_r1) << 4) - 33'(sm_r1));

  always_ff @(posedge clk) begin
    sm_r1  <= div_q[DIV_QB];
    sm_r2  <= DIV_QB'((56'(div_q[DIV_QB]) * 56'(div_q[DIV_QB])) >> 28);
    sm_r3  <= DIV_QB'((56'(sm_r2) * 56'(sm_r1)) >> 28);
    sm_p   <= 32'(sm_p_c);
    sm_s   <= 33'((60'(sm_r3) * 60'(sm_p)) >> 28);
    sm_g   <= 32'(((64'(sm_s) << GF) + (64'd1 << 27)) >> 28);
    // hold the plain quotient for linear and logarithmic modes
    q_d[0] <= 32'(div_q[DIV_QB]);
    q_d[1] <= q_d[0];
    q_d[2] <= q_d[1];
    q_d[3] <= q_d[2];
  end

  // --------------------------------------------------------------------------
  // Stages 35..66: exp2 of the scaled exponent, gain = 2^-b
  // --------------------------------------------------------------------------
  logic [50:0] exp_prod;
  logic [42:0] exp_b;
  logic [30:0] exp_p  [0:EXP_ROUNDS];
  logic [29:0] exp_fr [0:EXP_ROUNDS];
  logic [12:0] exp_ip [0:EXP_ROUNDS];
  logic [6:0]  exp_sh;
  logic [63:0] exp_sum;
  logic [31:0] exp_g;

  assign exp_prod = 51'(exp_a) * 51'(falloff_exponent);
  assign exp_b    = exp_prod[50:8];

  always_ff @(posedge clk) begin
    exp_p[0]  <= 31'd1 << 30;
    exp_fr[0] <= exp_b[29:0];
    exp_ip[0] <= exp_b[42:30];
  end

  for (genvar j = 1; j <= EXP_ROUNDS; j++) begin : g_exp
    localparam logic [29:0] FACTOR = exp_factor(j);
    always_ff @(posedge clk) begin
      if (exp_fr[j-1][EXP_ROUNDS-j]) begin
        exp_p[j] <= 31'((61'(exp_p[j-1]) * 61'(FACTOR)) >> 30);
      end else begin
        exp_p[j] <= exp_p[j-1];
      end
      exp_fr[j] <= exp_fr[j-1];
      exp_ip[j] <= exp_ip[j-1];
    end
  end

  assign exp_sh  = 7'd30 + {1'b0, exp_ip[EXP_ROUNDS][5:0]};
  assign exp_sum = (64'(exp_p[EXP_ROUNDS]) << GF) + (64'd1 << (exp_sh - 7'd1));

  always_ff @(posedge clk) begin
    // a very large exponent silences the source
    if (exp_ip[EXP_ROUNDS] > 13'd32) begin
      exp_g <= '0;
    end else begin
      exp_g <= 32'(exp_sum >> exp_sh);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 67: select the curve, saturate, drive the result
  // --------------------------------------------------------------------------
  logic [31:0]   pick;
  logic [GW-1:0] gsat;
  logic [GW-1:0] gain_q;

  always_comb begin
    case (ctl[LAT-1].cls)
      CLS_ONE:  pick = 32'(GAIN_ONE);
      CLS_ZERO: pick = '0;
      CLS_CURVE: begin
        case (ctl[LAT-1].mode)
          MODE_EXP:    pick = exp_g;
          MODE_SMOOTH: pick = sm_g;
          default:     pick = q_d[3];
        endcase
      end
      default: pick = '0;
    endcase
    gsat = (pick > 32'(GAIN_ONE)) ? GAIN_ONE : pick[GW-1:0];
  end

  always_ff @(posedge clk) begin
    gain_q <= gsat;
  end

  assign done = ctl[LAT].valid;
  assign gain = 16'(gain_q);

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT + 1))
    else $error("result without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT + 1) done)
    else $error("request lost in the pipeline");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    done |-> gain_q <= GAIN_ONE)
    else $error("gain above full volume");

  a_zero_class: assert property (@(posedge clk) disable iff (rst)
    (ctl[LAT-1].valid && ctl[LAT-1].cls == CLS_ZERO) |=> gain_q == '0)
    else $error("silent distance gave nonzero gain");
`endif

endmodule
